FILE: hdl/command_frame_checker_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the command frame checker
// Shared shorthand for concurrent checks clocked on clk and held off in reset.
// ---------------------------------------------------------------------------
`ifndef COMMAND_FRAME_CHECKER_ASSERT_SVH
`define COMMAND_FRAME_CHECKER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CFC_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CFC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/cfc_pkg.sv
// ---------------------------------------------------------------------------
// Command frame checker package
// Shared types, register map, status codes and the CRC and clamp helpers.
// ---------------------------------------------------------------------------
package cfc_pkg;

  localparam int MAX_FRAME_BYTES = 64;
  localparam int MIN_FRAME_BYTES = 4;
  localparam int ADDR_W          = 5;
  localparam int DATA_W          = 32;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;
  localparam logic [7:0]  MODE_MASK = 8'h03;

  localparam logic [2:0] REG_BOARD_ADDRESS = 3'd0;
  localparam logic [2:0] REG_DRIVE1_MAX    = 3'd1;
  localparam logic [2:0] REG_DRIVE1_MIN    = 3'd2;
  localparam logic [2:0] REG_DRIVE2_MAX    = 3'd3;
  localparam logic [2:0] REG_DRIVE2_MIN    = 3'd4;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_CRC_BAD   = 3'd1,
    ST_ADDR_BAD  = 3'd2,
    ST_TOO_SHORT = 3'd3,
    ST_TOO_LONG  = 3'd4
  } status_t;

  typedef struct packed {
    logic [7:0] board_address;
    logic [7:0] drive1_max;
    logic [7:0] drive1_min;
    logic [7:0] drive2_max;
    logic [7:0] drive2_min;
  } cfg_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

  function automatic logic [7:0] clamp_level(input logic [7:0] v, input logic [7:0] hi,
                                             input logic [7:0] lo);
    logic [7:0] t;
    t = (v > hi) ? hi : v;
    t = (t < lo) ? lo : t;
    return t;
  endfunction

endpackage

FILE: hdl/command_frame_checker.sv
// A result is computed from the final byte in the input register and then registered in the output register.
// Throughput: one byte per cycle while in_stall is low; the frame state and CRC update once per byte.
// A final byte waits in the input register only while an untaken result holds
// the output register.
// Reset (synchronous, rst_n low) clears the frame state and loads register defaults.
// ---------------------------------------------------------------------------
// Command frame checker
// Checks CRC-16, board address and length of a byte stream command frame and
// reports its status, mode bits, clamped drive levels and computed CRC.
// ---------------------------------------------------------------------------
module command_frame_checker (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [7:0]                  in_data_byte,
  input  logic                        in_last_byte,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [2:0]                  out_status,
  output logic [1:0]                  out_mode_bits,
  output logic [7:0]                  out_drive1_level,
  output logic [7:0]                  out_drive2_level,
  output logic [15:0]                 out_computed_crc,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [cfc_pkg::ADDR_W-1:0]  paddr,
  input  logic [cfc_pkg::DATA_W-1:0]  pwdata,
  output logic [cfc_pkg::DATA_W-1:0]  prdata,
  output logic                        pready
);

  `include "command_frame_checker_assert.svh"

  cfc_pkg::cfg_t cfg;

  logic        s1_valid_r, s1_valid_nxt;
  logic [7:0]  s1_byte_r;
  logic        s1_last_r;
  logic        in_accept;
  logic        advance;
  logic        out_load;

  logic [15:0] crc_r, crc_nxt;
  logic [7:0]  count_r, count_nxt;
  logic [7:0]  held0_r, held0_nxt;
  logic [7:0]  held1_r, held1_nxt;
  logic [7:0]  first_r, first_nxt;
  logic [1:0]  mode_r, mode_nxt;
  logic [7:0]  drv1_r, drv1_nxt;
  logic [7:0]  drv2_r, drv2_nxt;
  logic        ovf_r, ovf_nxt;

  logic [15:0] crc_upd;
  logic [7:0]  held0_upd, held1_upd, first_upd, drv1_upd, drv2_upd;
  logic [1:0]  mode_upd;
  cfc_pkg::status_t status;

  logic        out_valid_r, out_valid_nxt;
  logic [2:0]  out_status_r;
  logic [1:0]  out_mode_r;
  logic [7:0]  out_drv1_r;
  logic [7:0]  out_drv2_r;
  logic [15:0] out_crc_r;

  logic        out_blocked;
  logic        frame_clear;
  logic        status_legal;
  logic        len_err;
  logic        fields_zero;

  cfc_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign advance   = s1_valid_r & (~s1_last_r | ~out_valid_r | ~out_stall);
  assign in_stall  = s1_valid_r & ~advance;
  assign in_accept = in_valid & ~in_stall;
  assign out_load  = advance & s1_last_r;

  always_comb begin
    if (in_accept) begin
      s1_valid_nxt = 1'b1;
    end else if (advance) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end
  end

  always_comb begin
    ovf_nxt   = ovf_r | (count_r >= 8'(cfc_pkg::MAX_FRAME_BYTES));
    crc_upd   = crc_r;
    held0_upd = held0_r;
    held1_upd = held1_r;
    first_upd = first_r;
    mode_upd  = mode_r;
    drv1_upd  = drv1_r;
    drv2_upd  = drv2_r;
    if (!ovf_nxt) begin
      if (count_r >= 8'd2) begin
        crc_upd = cfc_pkg::crc_byte(crc_r, held0_r);
      end
      held0_upd = held1_r;
      held1_upd = s1_byte_r;
      case (count_r)
        8'd0:    first_upd = s1_byte_r;
        8'd1:    mode_upd  = s1_byte_r[1:0] & cfc_pkg::MODE_MASK[1:0];
        8'd2:    drv1_upd  = s1_byte_r;
        8'd3:    drv2_upd  = s1_byte_r;
        default: first_upd = first_r;
      endcase
    end
    count_nxt = (count_r == 8'hFF) ? count_r : count_r + 8'd1;

    if (ovf_nxt) begin
      status = cfc_pkg::ST_TOO_LONG;
    end else if (count_r < 8'(cfc_pkg::MIN_FRAME_BYTES - 1)) begin
      status = cfc_pkg::ST_TOO_SHORT;
    end else if (crc_upd != {held0_upd, held1_upd}) begin
      status = cfc_pkg::ST_CRC_BAD;
    end else if (first_upd != cfg.board_address) begin
      status = cfc_pkg::ST_ADDR_BAD;
    end else begin
      status = cfc_pkg::ST_OK;
    end

    crc_nxt   = crc_upd;
    held0_nxt = held0_upd;
    held1_nxt = held1_upd;
    first_nxt = first_upd;
    mode_nxt  = mode_upd;
    drv1_nxt  = drv1_upd;
    drv2_nxt  = drv2_upd;
    if (s1_last_r) begin
      crc_nxt   = cfc_pkg::CRC_INIT;
      count_nxt = 8'd0;
      held0_nxt = 8'd0;
      held1_nxt = 8'd0;
      first_nxt = 8'd0;
      mode_nxt  = 2'd0;
      drv1_nxt  = 8'd0;
      drv2_nxt  = 8'd0;
      ovf_nxt   = 1'b0;
    end
  end

  assign out_valid_nxt = out_load | (out_valid_r & out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      crc_r       <= cfc_pkg::CRC_INIT;
      count_r     <= 8'd0;
      held0_r     <= 8'd0;
      held1_r     <= 8'd0;
      first_r     <= 8'd0;
      mode_r      <= 2'd0;
      drv1_r      <= 8'd0;
      drv2_r      <= 8'd0;
      ovf_r       <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (advance) begin
        crc_r   <= crc_nxt;
        count_r <= count_nxt;
        held0_r <= held0_nxt;
        held1_r <= held1_nxt;
        first_r <= first_nxt;
        mode_r  <= mode_nxt;
        drv1_r  <= drv1_nxt;
        drv2_r  <= drv2_nxt;
        ovf_r   <= ovf_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_byte_r <= in_data_byte;
      s1_last_r <= in_last_byte;
    end
    if (out_load) begin
      out_status_r <= status;
      if (status == cfc_pkg::ST_TOO_LONG || status == cfc_pkg::ST_TOO_SHORT) begin
        out_mode_r <= 2'd0;
        out_drv1_r <= 8'd0;
        out_drv2_r <= 8'd0;
        out_crc_r  <= 16'd0;
      end else begin
        out_mode_r <= mode_upd;
        out_drv1_r <= cfc_pkg::clamp_level(drv1_upd, cfg.drive1_max, cfg.drive1_min);
        out_drv2_r <= cfc_pkg::clamp_level(drv2_upd, cfg.drive2_max, cfg.drive2_min);
        out_crc_r  <= crc_upd;
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_mode_bits    = out_mode_r;
  assign out_drive1_level = out_drv1_r;
  assign out_drive2_level = out_drv2_r;
  assign out_computed_crc = out_crc_r;

  assign out_blocked  = s1_last_r & out_valid_r & out_stall;
  assign frame_clear  = (count_r == 8'd0) && (crc_r == cfc_pkg::CRC_INIT) && !ovf_r;
  assign status_legal = out_status_r <= cfc_pkg::ST_TOO_LONG;
  assign len_err      = out_valid_r && (out_status_r >= cfc_pkg::ST_TOO_SHORT);
  assign fields_zero  = (out_crc_r == 16'd0) && (out_drv1_r == 8'd0) && (out_drv2_r == 8'd0);

  `CFC_ASSERT_SAME(a_stall_cause, in_stall, s1_valid_r && out_blocked, "Spurious input stall.")
  `CFC_ASSERT_NEXT(a_frame_clear, out_load, frame_clear, "Frame state not cleared.")
  `CFC_ASSERT_SAME(a_status_range, out_valid_r, status_legal, "Result status code out of range.")
  `CFC_ASSERT_SAME(a_length_zeroed, len_err, fields_zero, "Length error with nonzero fields.")

endmodule

FILE: hdl/cfc_regs.sv
// ---------------------------------------------------------------------------
// Command frame checker register file
// APB-style write and read access to the address and drive clamp registers.
// ---------------------------------------------------------------------------
module cfc_regs (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [cfc_pkg::ADDR_W-1:0]  paddr,
  input  logic [cfc_pkg::DATA_W-1:0]  pwdata,
  output logic [cfc_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  output cfc_pkg::cfg_t               cfg
);

  cfc_pkg::cfg_t cfg_r;
  cfc_pkg::cfg_t cfg_nxt;
  logic [2:0]    reg_idx;
  logic          wr_en;
  logic [7:0]    rd_val;

  assign reg_idx = paddr[cfc_pkg::ADDR_W-1:2];
  assign wr_en   = psel & penable & pwrite;
  assign pready  = 1'b1;
  assign cfg     = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (reg_idx)
        cfc_pkg::REG_BOARD_ADDRESS: cfg_nxt.board_address = pwdata[7:0];
        cfc_pkg::REG_DRIVE1_MAX:    cfg_nxt.drive1_max    = pwdata[7:0];
        cfc_pkg::REG_DRIVE1_MIN:    cfg_nxt.drive1_min    = pwdata[7:0];
        cfc_pkg::REG_DRIVE2_MAX:    cfg_nxt.drive2_max    = pwdata[7:0];
        cfc_pkg::REG_DRIVE2_MIN:    cfg_nxt.drive2_min    = pwdata[7:0];
        default:                    cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      cfc_pkg::REG_BOARD_ADDRESS: rd_val = cfg_r.board_address;
      cfc_pkg::REG_DRIVE1_MAX:    rd_val = cfg_r.drive1_max;
      cfc_pkg::REG_DRIVE1_MIN:    rd_val = cfg_r.drive1_min;
      cfc_pkg::REG_DRIVE2_MAX:    rd_val = cfg_r.drive2_max;
      cfc_pkg::REG_DRIVE2_MIN:    rd_val = cfg_r.drive2_min;
      default:                    rd_val = 8'h00;
    endcase
  end

  assign prdata = {{(cfc_pkg::DATA_W-8){1'b0}}, rd_val};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.board_address <= 8'd1;
      cfg_r.drive1_max    <= 8'hFF;
      cfg_r.drive1_min    <= 8'h00;
      cfg_r.drive2_max    <= 8'hFF;
      cfg_r.drive2_min    <= 8'h00;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule
